@@ design/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and codes for the texture combiner stage.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_COLOR_OP  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_OP  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_MA  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_MB  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_MC  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_MA  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_MB  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_MC  = 3'd7;

  localparam logic [3:0] OP_REPLACE   = 4'd0;
  localparam logic [3:0] OP_MODULATE  = 4'd1;
  localparam logic [3:0] OP_ADD       = 4'd2;
  localparam logic [3:0] OP_ADDSIGNED = 4'd3;
  localparam logic [3:0] OP_LERP      = 4'd4;
  localparam logic [3:0] OP_SUB       = 4'd5;
  localparam logic [3:0] OP_DOT3RGB   = 4'd6;
  localparam logic [3:0] OP_DOT3RGBA  = 4'd7;
  localparam logic [3:0] OP_MADD      = 4'd8;
  localparam logic [3:0] OP_ADDMUL    = 4'd9;

  localparam logic [2:0] CSEL_RGB = 3'd0;
  localparam logic [2:0] CSEL_AAA = 3'd1;
  localparam logic [2:0] CSEL_RRR = 3'd2;
  localparam logic [2:0] CSEL_GGG = 3'd3;
  localparam logic [2:0] CSEL_BBB = 3'd4;

  localparam logic [1:0] ASEL_A = 2'd0;
  localparam logic [1:0] ASEL_R = 2'd1;
  localparam logic [1:0] ASEL_G = 2'd2;
  localparam logic [1:0] ASEL_B = 2'd3;

  localparam int unsigned Lanes = 4;

  typedef struct packed {
    logic [31:0] source_a_rgba;
    logic [31:0] source_b_rgba;
    logic [31:0] source_c_rgba;
  } tcs_in_t;

  typedef struct packed {
    logic [23:0] result_rgb;
    logic [7:0]  result_alpha;
    logic        unsupported_op;
  } tcs_out_t;

  typedef struct packed {
    logic               use_div;
    logic [15:0]        prod;
    logic [7:0]         cadd;
    logic [7:0]         simple;
    logic signed [17:0] dot_p;
  } tcs_prep_t;

endpackage

@@ design/tcs_operand_sel.sv @@
// ----------------------------------------------------------------------------
// tcs_operand_sel
// Picks the colour operand and the alpha operand from one RGBA source.
// ----------------------------------------------------------------------------
module tcs_operand_sel
  import tcs_pkg::*;
(
  input  logic [31:0] rgba_i,
  input  logic [3:0]  cmod_i,
  input  logic [2:0]  amod_i,
  output logic [7:0]  color_o [3],
  output logic [7:0]  alpha_o
);

  logic [7:0] r, g, b, a, av;
  logic [7:0] cv [3];
  logic       cvalid;

  assign r = rgba_i[31:24];
  assign g = rgba_i[23:16];
  assign b = rgba_i[15:8];
  assign a = rgba_i[7:0];

  always_comb begin
    cvalid = 1'b1;
    cv[0] = 8'd0;
    cv[1] = 8'd0;
    cv[2] = 8'd0;
    case (cmod_i[3:1])
      CSEL_RGB: begin
        cv[0] = r; cv[1] = g; cv[2] = b;
      end
      CSEL_AAA: begin
        cv[0] = a; cv[1] = a; cv[2] = a;
      end
      CSEL_RRR: begin
        cv[0] = r; cv[1] = r; cv[2] = r;
      end
      CSEL_GGG: begin
        cv[0] = g; cv[1] = g; cv[2] = g;
      end
      CSEL_BBB: begin
        cv[0] = b; cv[1] = b; cv[2] = b;
      end
      default: cvalid = 1'b0;
    endcase
    for (int i = 0; i < 3; i++) begin
      color_o[i] = (cvalid && cmod_i[0]) ? (8'd255 - cv[i]) : cv[i];
    end
  end

  always_comb begin
    case (amod_i[2:1])
      ASEL_A:  av = a;
      ASEL_R:  av = r;
      ASEL_G:  av = g;
      ASEL_B:  av = b;
      default: av = a;
    endcase
    alpha_o = amod_i[0] ? (8'd255 - av) : av;
  end

endmodule

@@ design/tcs_lane_prep.sv @@
// ----------------------------------------------------------------------------
// tcs_lane_prep
// Product stage of one byte lane: numerators for the divide-by-255 ops,
// simple results for the others, and the signed dot3 product.
// ----------------------------------------------------------------------------
module tcs_lane_prep
  import tcs_pkg::*;
(
  input  logic [3:0] op_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] c_i,
  output tcs_prep_t  prep_o
);

  logic [15:0]        ab, ac, bnc, sumc;
  logic [8:0]         sum9;
  logic [7:0]         sat, nc;
  logic signed [9:0]  ssum, xs, ys;
  logic signed [19:0] dprod;

  assign nc    = 8'd255 - c_i;
  assign ab    = {8'd0, a_i} * {8'd0, b_i};
  assign ac    = {8'd0, a_i} * {8'd0, c_i};
  assign bnc   = {8'd0, b_i} * {8'd0, nc};
  assign sum9  = {1'b0, a_i} + {1'b0, b_i};
  assign sat   = sum9[8] ? 8'd255 : sum9[7:0];
  assign sumc  = {8'd0, sat} * {8'd0, c_i};
  assign ssum  = $signed({2'b00, a_i}) + $signed({2'b00, b_i}) - 10'sd128;
  assign xs    = $signed({1'b0, a_i, 1'b0}) - 10'sd255;
  assign ys    = $signed({1'b0, b_i, 1'b0}) - 10'sd255;
  assign dprod = xs * ys + 20'sd128;

  always_comb begin
    prep_o.use_div = 1'b0;
    prep_o.prod    = ab;
    prep_o.cadd    = 8'd0;
    prep_o.simple  = 8'd0;
    prep_o.dot_p   = dprod[17:0];
    case (op_i)
      OP_REPLACE:  prep_o.simple = a_i;
      OP_MODULATE: prep_o.use_div = 1'b1;
      OP_ADD:      prep_o.simple = sat;
      OP_ADDSIGNED: begin
        if (ssum < 0) prep_o.simple = 8'd0;
        else if (ssum > 10'sd255) prep_o.simple = 8'd255;
        else prep_o.simple = ssum[7:0];
      end
      OP_LERP: begin
        prep_o.use_div = 1'b1;
        prep_o.prod    = ac + bnc;
      end
      OP_SUB: prep_o.simple = (a_i > b_i) ? (a_i - b_i) : 8'd0;
      OP_MADD: begin
        prep_o.use_div = 1'b1;
        prep_o.cadd    = c_i;
      end
      OP_ADDMUL: begin
        prep_o.use_div = 1'b1;
        prep_o.prod    = sumc;
      end
      default: prep_o.simple = 8'd0;
    endcase
  end

endmodule

@@ design/tcs_lane_final.sv @@
// ----------------------------------------------------------------------------
// tcs_lane_final
// Final stage of one byte lane: divide by 255, offset and clamp, and the
// dot3 term divided by 256 towards zero.
// ----------------------------------------------------------------------------
module tcs_lane_final
  import tcs_pkg::*;
(
  input  tcs_prep_t         prep_i,
  output logic [7:0]        res_o,
  output logic signed [8:0] term_o
);

  logic [16:0]        qsum;
  logic [8:0]         q, total;
  logic signed [17:0] padj, tsh;

  // floor(x/255) for x below 65535
  assign qsum  = {1'b0, prep_i.prod} + 17'd1 + {9'd0, prep_i.prod[15:8]};
  assign q     = qsum[16:8];
  assign total = q + {1'b0, prep_i.cadd};

  assign padj   = (prep_i.dot_p < 0) ? (prep_i.dot_p + 18'sd255) : prep_i.dot_p;
  assign tsh    = padj >>> 8;
  assign term_o = tsh[8:0];

  always_comb begin
    if (prep_i.use_div) begin
      res_o = total[8] ? 8'd255 : total[7:0];
    end else begin
      res_o = prep_i.simple;
    end
  end

endmodule

@@ design/texture_combiner_stage_unit.sv @@
// ----------------------------------------------------------------------------
// texture_combiner_stage_unit
// Texture combiner stage: operand select, product, divide/clamp pipeline.
// ----------------------------------------------------------------------------
// Stages: operand, product and result registers lie between input transfer
// and out_valid_o.
// Throughput: one fragment per cycle if out_stall_i is low; a stage moves
// whenever the next one is empty or moving, so bubbles close up under stall.
// Reset: valid bits and all configuration registers clear to zero.
module texture_combiner_stage_unit
  import tcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcs_out_t            out_data_o
);

  logic [3:0] color_op_q, alpha_op_q, cmod_a_q, cmod_b_q, cmod_c_q;
  logic [2:0] amod_a_q, amod_b_q, amod_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_op_q <= '0;
      alpha_op_q <= '0;
      cmod_a_q   <= '0;
      cmod_b_q   <= '0;
      cmod_c_q   <= '0;
      amod_a_q   <= '0;
      amod_b_q   <= '0;
      amod_c_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_OP: color_op_q <= cfg_wdata_i;
        CFG_ALPHA_OP: alpha_op_q <= cfg_wdata_i;
        CFG_COLOR_MA: cmod_a_q   <= cfg_wdata_i;
        CFG_COLOR_MB: cmod_b_q   <= cfg_wdata_i;
        CFG_COLOR_MC: cmod_c_q   <= cfg_wdata_i;
        CFG_ALPHA_MA: amod_a_q   <= cfg_wdata_i[2:0];
        CFG_ALPHA_MB: amod_b_q   <= cfg_wdata_i[2:0];
        CFG_ALPHA_MC: amod_c_q   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q;
  logic mv1, mv2, mv3;

  assign mv3        = !v3_q || !out_stall_i;
  assign mv2        = !v2_q || mv3;
  assign mv1        = !v1_q || mv2;
  assign in_stall_o = !mv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (mv1) v1_q <= in_valid_i;
      if (mv2) v2_q <= v1_q;
      if (mv3) v3_q <= v2_q;
    end
  end

  // stage 1: operand select
  logic [7:0] col_a [3], col_b [3], col_c [3];
  logic [7:0] alp_a, alp_b, alp_c;
  logic [7:0] opa_d [Lanes], opb_d [Lanes], opc_d [Lanes];
  logic [7:0] opa_q [Lanes], opb_q [Lanes], opc_q [Lanes];

  tcs_operand_sel u_sel_a (
    .rgba_i (in_data_i.source_a_rgba),
    .cmod_i (cmod_a_q),
    .amod_i (amod_a_q),
    .color_o(col_a),
    .alpha_o(alp_a)
  );

  tcs_operand_sel u_sel_b (
    .rgba_i (in_data_i.source_b_rgba),
    .cmod_i (cmod_b_q),
    .amod_i (amod_b_q),
    .color_o(col_b),
    .alpha_o(alp_b)
  );

  tcs_operand_sel u_sel_c (
    .rgba_i (in_data_i.source_c_rgba),
    .cmod_i (cmod_c_q),
    .amod_i (amod_c_q),
    .color_o(col_c),
    .alpha_o(alp_c)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa_d[i] = col_a[i];
      opb_d[i] = col_b[i];
      opc_d[i] = col_c[i];
    end
    opa_d[3] = alp_a;
    opb_d[3] = alp_b;
    opc_d[3] = alp_c;
  end

  always_ff @(posedge clk_i) begin
    if (mv1 && in_valid_i) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
      opc_q <= opc_d;
    end
  end

  // stage 2: products
  tcs_prep_t prep_d [Lanes];
  tcs_prep_t prep_q [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_prep
    tcs_lane_prep u_prep (
      .op_i  ((l == Lanes - 1) ? alpha_op_q : color_op_q),
      .a_i   (opa_q[l]),
      .b_i   (opb_q[l]),
      .c_i   (opc_q[l]),
      .prep_o(prep_d[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (mv2 && v1_q) begin
      prep_q <= prep_d;
    end
  end

  // stage 3: divide, dot3 sum, clamp
  logic [7:0]         lres [Lanes];
  logic signed [8:0]  term [Lanes];
  logic signed [10:0] dsum;
  logic [7:0]         dclamp;
  logic               is_dot3, alpha_ok;
  tcs_out_t           out_d, out_q;

  for (genvar l = 0; l < Lanes; l++) begin : g_final
    tcs_lane_final u_final (
      .prep_i(prep_q[l]),
      .res_o (lres[l]),
      .term_o(term[l])
    );
  end

  assign dsum = 11'(term[0]) + 11'(term[1]) + 11'(term[2]);
  assign is_dot3 = (color_op_q == OP_DOT3RGB) || (color_op_q == OP_DOT3RGBA);

  always_comb begin
    if (dsum < 0) dclamp = 8'd0;
    else if (dsum > 11'sd255) dclamp = 8'd255;
    else dclamp = dsum[7:0];
  end

  always_comb begin
    case (alpha_op_q)
      OP_REPLACE, OP_MODULATE, OP_ADD, OP_ADDSIGNED, OP_LERP, OP_SUB,
      OP_MADD, OP_ADDMUL: alpha_ok = 1'b1;
      default:            alpha_ok = 1'b0;
    endcase
  end

  always_comb begin
    out_d.result_rgb     = is_dot3 ? {dclamp, dclamp, dclamp} : {lres[0], lres[1], lres[2]};
    out_d.result_alpha   = alpha_ok ? lres[3] : 8'd0;
    out_d.unsupported_op = !alpha_ok;
  end

  always_ff @(posedge clk_i) begin
    if (mv3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && out_stall_i |-> in_stall_o)
    else $error("full pipeline accepted under stall");

  a_unsup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unsupported_op |-> out_data_o.result_alpha == 8'd0)
    else $error("unsupported alpha op with non-zero alpha");

  a_dot3_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_dot3 |->
      out_data_o.result_rgb[23:16] == out_data_o.result_rgb[15:8] &&
      out_data_o.result_rgb[15:8] == out_data_o.result_rgb[7:0])
    else $error("dot3 result not replicated");
`endif

endmodule
